[hdl/dq_pkg.sv]
// Shared types and codes for the double-ended queue.
package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Command broadcast to every cell of a chain. "Near" is the chain's cell 0.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUSH_NEAR,
        CMD_PUSH_FAR,
        CMD_POP_NEAR,
        CMD_ROTATE
    } t_cmd;

endpackage

[hdl/dq_cell.sv]
// One storage cell of a deque chain: holds a word and trades it with its neighbors.
module dq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  dq_pkg::t_cmd          i_cmd,
    input  logic [CW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_new,
    input  logic [DATA_WIDTH-1:0] i_wrap,
    input  logic [DATA_WIDTH-1:0] i_prev,
    input  logic [DATA_WIDTH-1:0] i_next,
    output logic [DATA_WIDTH-1:0] o_data
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_is_free;
    logic                  w_is_tail;

    assign w_is_free = (CW'(INDEX) == i_count);
    assign w_is_tail = (CW'(INDEX + 1) == i_count);

    always_comb begin
        n_data = r_data;
        case (i_cmd)
            CMD_PUSH_NEAR: n_data = (INDEX == 0) ? i_new : i_prev;
            CMD_PUSH_FAR:  if (w_is_free) n_data = i_new;
            CMD_POP_NEAR:  n_data = i_next;
            // close the ring: the tail takes the word leaving cell 0
            CMD_ROTATE:    n_data = w_is_tail ? i_wrap : i_next;
            default:       n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[hdl/dq_chain.sv]
// Row of deque cells, compacted toward cell 0, with shift, append and rotate.
module dq_chain #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5
) (
    input  logic                  i_clk,
    input  dq_pkg::t_cmd          i_cmd,
    input  logic [CW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_new,
    output logic [DATA_WIDTH-1:0] o_near
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        logic [DATA_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_new;
        end else begin : g_mid_prev
            assign w_prev = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_next
            assign w_next = w_data[g+1];
        end

        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_count (i_count),
            .i_new   (i_new),
            .i_wrap  (w_data[0]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_data  (w_data[g])
        );
    end

    assign o_near = w_data[0];

endmodule

[hdl/double_ended_queue.sv]
// Top level of the bounded double-ended queue built from two mirrored cell chains.
//
// A bounded deque of DEPTH signed words. The contents are kept twice, in two rows of
// cells: one row holds the front word in its first cell, the other holds the rear word
// in its first cell, so every push and pop touches only fixed cells and neighbor
// shifts. Push and pop requests are accepted back to back, one per cycle, as long as
// the result register drains. A dump gives one result per stored entry, rotating the
// front row once around so the contents are unchanged at the end; no new request is
// accepted during a dump. A push on a full deque returns status full and is dropped;
// a pop or dump on an empty deque returns status empty. Request codes 5 to 7 are
// ignored and give no result. Results carry last high on the final result of each
// request.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [dq_pkg::REQ_W-1:0]   i_req_type,
    input  logic signed [dq_pkg::VALUE_W-1:0] i_push_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [dq_pkg::STATUS_W-1:0] o_status,
    output logic signed [dq_pkg::VALUE_W-1:0] o_value,
    output logic                       o_last
);
    import dq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state                  r_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_dump_left;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status;
    logic [VALUE_W-1:0]      r_value;
    logic                    r_last;

    logic                    w_slot;
    logic                    w_take;
    logic                    w_load;
    logic                    w_full;
    logic                    w_empty;
    t_cmd                    w_front_cmd;
    t_cmd                    w_rear_cmd;
    logic [DATA_WIDTH-1:0]   w_new;
    logic [DATA_WIDTH-1:0]   w_front_word;
    logic [DATA_WIDTH-1:0]   w_rear_word;
    logic [VALUE_W-1:0]      w_front_ext;
    logic [VALUE_W-1:0]      w_rear_ext;

    assign w_slot     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_slot;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // a result enters the output register in this cycle
    assign w_load = (r_state == ST_DUMP) ? w_slot :
                    (w_take && ((i_req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK,
                                                    REQ_POP_FRONT, REQ_POP_BACK}) ||
                                ((i_req_type == REQ_DUMP) && w_empty)));

    assign w_new       = DATA_WIDTH'(i_push_value);
    assign w_front_ext = VALUE_W'($signed(w_front_word));
    assign w_rear_ext  = VALUE_W'($signed(w_rear_word));

    // Front row: front word in cell 0. Rear row: rear word in cell 0.
    always_comb begin
        w_front_cmd = CMD_NONE;
        w_rear_cmd  = CMD_NONE;
        if (r_state == ST_DUMP) begin
            if (w_slot) w_front_cmd = CMD_ROTATE;
        end else if (w_take) begin
            unique case (i_req_type)
                REQ_PUSH_FRONT: begin
                    if (!w_full) begin
                        w_front_cmd = CMD_PUSH_NEAR;
                        w_rear_cmd  = CMD_PUSH_FAR;
                    end
                end
                REQ_PUSH_BACK: begin
                    if (!w_full) begin
                        w_front_cmd = CMD_PUSH_FAR;
                        w_rear_cmd  = CMD_PUSH_NEAR;
                    end
                end
                REQ_POP_FRONT: if (!w_empty) w_front_cmd = CMD_POP_NEAR;
                REQ_POP_BACK:  if (!w_empty) w_rear_cmd = CMD_POP_NEAR;
                default: begin
                    w_front_cmd = CMD_NONE;
                    w_rear_cmd  = CMD_NONE;
                end
            endcase
        end
    end

    dq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_front (
        .i_clk   (i_clk),
        .i_cmd   (w_front_cmd),
        .i_count (r_count),
        .i_new   (w_new),
        .o_near  (w_front_word)
    );

    dq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_rear (
        .i_clk   (i_clk),
        .i_cmd   (w_rear_cmd),
        .i_count (r_count),
        .i_new   (w_new),
        .o_near  (w_rear_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dump_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_last <= 1'b1;
                        unique case (i_req_type)
                            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                                r_value <= '0;
                                if (w_full) begin
                                    r_status <= STATUS_FULL;
                                end else begin
                                    r_status <= STATUS_OK;
                                    r_count  <= r_count + CW'(1);
                                end
                            end
                            REQ_POP_FRONT, REQ_POP_BACK: begin
                                if (w_empty) begin
                                    r_status <= STATUS_EMPTY;
                                    r_value  <= '0;
                                end else begin
                                    r_status <= STATUS_OK;
                                    r_count  <= r_count - CW'(1);
                                    r_value  <= (i_req_type == REQ_POP_FRONT) ?
                                                w_front_ext : w_rear_ext;
                                end
                            end
                            REQ_DUMP: begin
                                if (w_empty) begin
                                    r_status    <= STATUS_EMPTY;
                                    r_value     <= '0;
                                end else begin
                                    r_state     <= ST_DUMP;
                                    r_dump_left <= r_count;
                                end
                            end
                            default: ; // drop unknown requests
                        endcase
                    end
                end
                ST_DUMP: begin
                    if (w_slot) begin
                        r_status    <= STATUS_OK;
                        r_value     <= w_front_ext;
                        r_last      <= (r_dump_left == CW'(1));
                        r_dump_left <= r_dump_left - CW'(1);
                        if (r_dump_left == CW'(1)) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_last      = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_dump_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |=> $stable(r_count))
        else $error("entry count moved during dump");

    a_partial_only_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == ST_DUMP))
        else $error("non-final result outside a dump");

    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_dump_left != '0) && (r_dump_left <= r_count))
        else $error("dump counter out of range");

endmodule

[verif/tb_double_ended_queue.sv]
// Self-checking testbench for the bounded double-ended queue, with its own shadow deque.
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;
    localparam int IDX_W  = $clog2(DEPTH_DEF);

    // Request codes 5 to 7 carry no operation.
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
    localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_dq_result;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_ready;
    logic [REQ_W-1:0]           i_req_type   = '0;
    logic signed [VALUE_W-1:0]  i_push_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready  = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic signed [VALUE_W-1:0]  o_value;
    logic                       o_last;

    // Shadow copy of the deque contents
    logic [VALUE_W-1:0] shadow_words [QDEPTH];
    logic [IDX_W-1:0]   shadow_head  = '0;
    logic [IDX_W:0]     shadow_count = '0;

    t_dq_result awaited_results [$];
    t_dq_result due;
    int         mismatch_count  = 0;
    int         tx_gap_max      = 0;
    int         rx_gap_max      = 0;
    int         hold_off_cycles = 0;

    double_ended_queue DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_value      (o_value),
        .o_last       (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Append one expected result behind those already awaited.
    task automatic await_result(input t_dq_result r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    // Apply one accepted request to the shadow deque and queue the results it causes.
    task automatic shadow_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] word);
        t_dq_result       r;
        logic [IDX_W-1:0] pos;
        r.status = STATUS_OK;
        r.value  = '0;
        r.last   = 1'b1;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (shadow_count == QDEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    if (req == REQ_PUSH_FRONT) begin
                        shadow_head = shadow_head - 1'b1;
                        pos = shadow_head;
                    end else begin
                        pos = shadow_head + shadow_count[IDX_W-1:0];
                    end
                    shadow_words[pos] = word;
                    shadow_count++;
                end
                await_result(r);
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    if (req == REQ_POP_FRONT) begin
                        pos = shadow_head;
                        shadow_head = shadow_head + 1'b1;
                    end else begin
                        pos = shadow_head + shadow_count[IDX_W-1:0] - 1'b1;
                    end
                    shadow_count--;
                    r.value = shadow_words[pos];
                end
                await_result(r);
            end
            REQ_DUMP: begin
                if (shadow_count == 0) begin
                    r.status = STATUS_EMPTY;
                    await_result(r);
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        pos = shadow_head + i[IDX_W-1:0];
                        r.value = shadow_words[pos];
                        r.last  = (i + 1 == shadow_count);
                        await_result(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Offer one request after a random gap and hold it until the queue accepts it.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] word);
        int unsigned pause;
        pause = $urandom_range(tx_gap_max, 0);
        if (pause > 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_push_value <= word;
        do @(posedge i_clk); while (!o_in_ready);
        shadow_request(req, word);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        // let a dump in flight finish
        repeat (QDEPTH + 8) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_mix(input int count, input int push_pct, input int dump_pct);
        int unsigned      roll;
        logic [REQ_W-1:0] req;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 3)
                req = REQ_W'($urandom_range(REQ_LAST_UNUSED, REQ_FIRST_UNUSED));
            else if (roll < 3 + dump_pct)
                req = REQ_DUMP;
            else if (roll < 3 + dump_pct + push_pct)
                req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else
                req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
            send_request(req, pick_word());
        end
    endtask

    task automatic test_empty_requests();
        tx_gap_max = 2;
        rx_gap_max = 2;
        send_request(REQ_POP_FRONT, 32'h1234_5678);
        send_request(REQ_POP_BACK, '1);
        send_request(REQ_DUMP, '0);
        send_request(REQ_FIRST_UNUSED, 32'hDEAD_BEEF);
        send_request(REQ_FIRST_UNUSED + 3'd1, '0);
        send_request(REQ_LAST_UNUSED, '1);
    endtask

    task automatic test_directed_mix();
        // single entry popped from the rear
        send_request(REQ_PUSH_BACK, 32'h0000_0001);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFE);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, '0);
        send_request(REQ_PUSH_BACK, '1);
        send_request(REQ_PUSH_BACK, 32'hAAAA_AAAA);
        send_request(REQ_PUSH_FRONT, 32'h5555_5555);
        send_request(REQ_DUMP, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_DUMP, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
    endtask

    task automatic test_full_under_backpressure();
        tx_gap_max = 0;
        rx_gap_max = 3;
        while (shadow_count != 0) send_request(REQ_POP_BACK, pick_word());
        // stall the result side while the sender keeps pushing
        hold_off_cycles = 80;
        for (int n = 0; n < QDEPTH + 2; n++)
            send_request(n[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_word());
        send_request(REQ_DUMP, pick_word());
        send_request(REQ_PUSH_FRONT, pick_word());
        send_request(REQ_POP_FRONT, pick_word());
        send_request(REQ_PUSH_BACK, pick_word());
        send_request(REQ_POP_BACK, pick_word());
        while (shadow_count != 0)
            send_request($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, pick_word());
        send_request(REQ_POP_FRONT, pick_word());
    endtask

    task automatic test_sender_pause();
        tx_gap_max = 6;
        rx_gap_max = 6;
        random_mix(40, 60, 5);
        wait_drained();
        random_mix(30, 45, 5);
    endtask

    task automatic test_random_traffic();
        tx_gap_max = 12;
        rx_gap_max = 12;
        random_mix(50, 50, 6);
        tx_gap_max = 0;
        rx_gap_max = 0;
        random_mix(45, 50, 6);
        tx_gap_max = 3;
        rx_gap_max = 0;
        random_mix(45, 75, 4);
        tx_gap_max = 0;
        rx_gap_max = 4;
        random_mix(45, 20, 6);
        tx_gap_max = 12;
        rx_gap_max = 2;
        random_mix(40, 55, 8);
    endtask

    // Result side: random or long stalls, then wait for one transaction.
    initial begin : result_sink
        int unsigned pause;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else begin
                pause = $urandom_range(rx_gap_max, 0);
                if (pause > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (pause) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d value=%0d last=%0b",
                         $time, o_status, o_value, o_last);
                mismatch_count++;
            end else begin
                due = awaited_results[0];
                awaited_results.delete(0);
                if (o_status !== due.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, due.status, o_status);
                    mismatch_count++;
                end
                if (o_value !== due.value) begin
                    $display("%0t: value expected %0d actual %0d", $time, due.value, o_value);
                    mismatch_count++;
                end
                if (o_last !== due.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, due.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_requests();
        test_directed_mix();
        test_full_under_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
